// ===== hw/rtl/pcmb_pkg.sv =====
// ---------------------------------------------------------------------------
// pcmb_pkg: shared types and constants of the point cloud morph blender
// Codes, payload structs and the restoring-division step used by the front.
// ---------------------------------------------------------------------------
package pcmb_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int IDX_W          = 10;
    localparam int CNT_W          = 11;
    localparam int WGT_W          = 17;
    localparam int WQ_W           = 16;
    localparam int FRONT_STAGES   = WQ_W + 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int ONE_Q16        = 65536;

    // opcodes of an input beat
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_CALC   = 2'd2;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_FACTOR  = 2'd1;
    localparam logic [1:0] REG_COUNT_A = 2'd2;
    localparam logic [1:0] REG_COUNT_B = 2'd3;

    typedef enum logic [1:0] {
        KIND_LOAD_A,
        KIND_LOAD_B,
        KIND_CALC
    } kind_t;

    // one point, x in the lowest bits
    typedef struct packed {
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } pt_t;

    typedef struct packed {
        logic             mode;
        logic [WGT_W-1:0] factor;
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_b;
    } cfg_t;

    // command handed from front to back
    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
        logic [WGT_W-1:0] wgt;
        logic [1:0]       status;
        pt_t              pt;
    } cmd_t;

    // one restoring-division step: returns {quotient bit, new remainder}
    function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [CNT_W-1:0] d);
        logic [CNT_W:0] sh;
        sh = {rem, bit_in};
        if (sh >= {1'b0, d})
            return {1'b1, CNT_W'(sh - {1'b0, d})};
        else
            return {1'b0, sh[CNT_W-1:0]};
    endfunction

endpackage

// ===== hw/rtl/pcmb_ram.sv =====
// ---------------------------------------------------------------------------
// pcmb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module pcmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    // registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pcmb_front.sv =====
// ---------------------------------------------------------------------------
// pcmb_front: accepts and classifies input beats
// Runs the fold dividers and the progressive-weight divider as a pipeline,
// one quotient bit per stage, and hands commands to the queue.
// ---------------------------------------------------------------------------
module pcmb_front import pcmb_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_op,
    input  logic [IDX_W-1:0] in_idx,
    input  pt_t              in_pt,
    input  cfg_t             cfg,
    input  logic             q_full,
    output logic             push,
    output cmd_t             cmd
);

    typedef struct packed {
        logic             vld;
        kind_t            kind;
        logic [1:0]       status;
        logic [IDX_W-1:0] idx;
        pt_t              pt;
        logic [CNT_W-1:0] rem_a;
        logic             q_a;
        logic [CNT_W-1:0] rem_b;
        logic             q_b;
        logic [CNT_W-1:0] rem_w;
        logic [WQ_W-1:0]  quot_w;
    } fs_t;

    fs_t              stg_reg  [FRONT_STAGES];
    fs_t              stg_next [FRONT_STAGES];
    logic             fen;
    logic [CNT_W-1:0] na;
    logic [CNT_W-1:0] nb;
    logic [CNT_W-1:0] nr;
    logic [WGT_W-1:0] fsat;

    // saturated configuration
    assign na   = (32'(cfg.count_a) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : cfg.count_a;
    assign nb   = (32'(cfg.count_b) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : cfg.count_b;
    assign nr   = (na > nb) ? na : nb;
    assign fsat = (32'(cfg.factor) > ONE_Q16) ? WGT_W'(ONE_Q16) : cfg.factor;

    // whole pipeline holds when the last stage cannot enter the queue
    assign fen      = !stg_reg[FRONT_STAGES-1].vld || !q_full;
    assign in_ready = fen;

    // entry stage: classify the beat
    always_comb
    begin
        stg_next[0]        = '0;
        stg_next[0].idx    = in_idx;
        stg_next[0].pt     = in_pt;
        stg_next[0].rem_w  = {1'b0, in_idx};
        stg_next[0].status = ST_OK;
        case (in_op)
            OP_LOAD_A:
            begin
                stg_next[0].kind = KIND_LOAD_A;
                stg_next[0].vld  = in_valid && (32'(in_idx) < MAX_POINTS);
            end
            OP_LOAD_B:
            begin
                stg_next[0].kind = KIND_LOAD_B;
                stg_next[0].vld  = in_valid && (32'(in_idx) < MAX_POINTS);
            end
            OP_CALC:
            begin
                stg_next[0].kind = KIND_CALC;
                stg_next[0].vld  = in_valid;
                if (na == '0 || nb == '0)
                    stg_next[0].status = ST_EMPTY;
                else if ({1'b0, in_idx} >= nr)
                    stg_next[0].status = ST_RANGE;
            end
            default:
            begin
                stg_next[0].kind = KIND_CALC;
                stg_next[0].vld  = 1'b0;
            end
        endcase
    end

    // division stages: mod steps for the first IDX_W, weight steps for all
    for (genvar k = 1; k < FRONT_STAGES; k++)
    begin : g_div
        // index bit fed into the mod steps, MSB first
        localparam int BI = (k <= IDX_W) ? IDX_W - k : 0;

        logic [CNT_W:0] sa;
        logic [CNT_W:0] sb;
        logic [CNT_W:0] sw;

        always_comb
        begin
            sa = div_step(stg_reg[k-1].rem_a, stg_reg[k-1].idx[BI], na);
            sb = div_step(stg_reg[k-1].rem_b, stg_reg[k-1].idx[BI], nb);
            sw = div_step(stg_reg[k-1].rem_w, 1'b0, nr);
            stg_next[k] = stg_reg[k-1];
            if (k <= IDX_W)
            begin
                stg_next[k].rem_a = sa[CNT_W-1:0];
                stg_next[k].q_a   = sa[CNT_W];
                stg_next[k].rem_b = sb[CNT_W-1:0];
                stg_next[k].q_b   = sb[CNT_W];
            end
            stg_next[k].rem_w  = sw[CNT_W-1:0];
            stg_next[k].quot_w = {stg_reg[k-1].quot_w[WQ_W-2:0], sw[CNT_W]};
        end
    end

    for (genvar k = 0; k < FRONT_STAGES; k++)
    begin : g_stg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stg_reg[k] <= '0;
            else if (fen)
                stg_reg[k] <= stg_next[k];
        end
    end

    // fold, weight and command build from the last stage
    logic [18:0] t_w;
    fs_t         lst;

    assign lst = stg_reg[FRONT_STAGES-1];
    assign t_w = {1'b0, fsat, 1'b0} - {3'b000, lst.quot_w};

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = lst.kind;
        cmd.status = lst.status;
        cmd.pt     = lst.pt;
        if (lst.kind == KIND_CALC)
        begin
            cmd.addr_a = lst.q_a ? IDX_W'(na - CNT_W'(1) - lst.rem_a) : IDX_W'(lst.rem_a);
            cmd.addr_b = lst.q_b ? IDX_W'(nb - CNT_W'(1) - lst.rem_b) : IDX_W'(lst.rem_b);
            if (!cfg.mode)
                cmd.wgt = fsat;
            else if (t_w[18])
                cmd.wgt = '0;
            else if (32'(t_w) > ONE_Q16)
                cmd.wgt = WGT_W'(ONE_Q16);
            else
                cmd.wgt = t_w[WGT_W-1:0];
        end
        else
        begin
            cmd.addr_a = lst.idx;
            cmd.addr_b = lst.idx;
        end
    end

    assign push = lst.vld && fen;

endmodule

// ===== hw/rtl/pcmb_queue.sv =====
// ---------------------------------------------------------------------------
// pcmb_queue: short command queue between front and back
// Flop-based FIFO, depth a power of two.
// ---------------------------------------------------------------------------
module pcmb_queue import pcmb_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PW = $clog2(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   cnt_reg;

    assign full  = (cnt_reg == (PW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (PW+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (PW+1)'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue pop while empty");
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + (PW+1)'(1)))
        else $error("queue level lost a beat");

endmodule

// ===== hw/rtl/pcmb_back.sv =====
// ---------------------------------------------------------------------------
// pcmb_back: carries out queued commands
// Loads write the point memories; computes read both sets, multiply,
// sum and land in the output register.
// ---------------------------------------------------------------------------
module pcmb_back import pcmb_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         head,
    input  logic         empty,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // x, y, z, red, green, blue
    output logic [1:0]   m_tuser    // status
);

    localparam int AW = $clog2(MAX_POINTS);

    logic ben;
    logic re;
    pt_t  rd_a;
    pt_t  rd_b;

    // stage registers
    logic             v1_reg, v2_reg, v3_reg;
    logic [WGT_W-1:0] w1_reg;
    logic [1:0]       st1_reg, st2_reg, st3_reg;
    logic signed [49:0] pca_reg [3];
    logic signed [49:0] pcb_reg [3];
    logic [24:0]        pka_reg [3];
    logic [24:0]        pkb_reg [3];
    pt_t                out_reg;
    pt_t                out_next;

    assign ben = !v3_reg || m_tready;
    assign pop = ben && !empty;
    assign re  = pop && (head.kind == KIND_CALC);

    pcmb_ram #(.WIDTH($bits(pt_t)), .DEPTH(MAX_POINTS)) u_ram_a (
        .clk   (clk),
        .we    (pop && (head.kind == KIND_LOAD_A)),
        .waddr (AW'(head.addr_a)),
        .wdata (head.pt),
        .re    (re),
        .raddr (AW'(head.addr_a)),
        .rdata (rd_a)
    );

    pcmb_ram #(.WIDTH($bits(pt_t)), .DEPTH(MAX_POINTS)) u_ram_b (
        .clk   (clk),
        .we    (pop && (head.kind == KIND_LOAD_B)),
        .waddr (AW'(head.addr_b)),
        .wdata (head.pt),
        .re    (re),
        .raddr (AW'(head.addr_b)),
        .rdata (rd_b)
    );

    // channel views of the read data
    logic signed [31:0] ca [3];
    logic signed [31:0] cb [3];
    logic [7:0]         ka [3];
    logic [7:0]         kb [3];
    logic [WGT_W-1:0]   wa;

    assign ca[0] = rd_a.x;  assign ca[1] = rd_a.y;  assign ca[2] = rd_a.z;
    assign cb[0] = rd_b.x;  assign cb[1] = rd_b.y;  assign cb[2] = rd_b.z;
    assign ka[0] = rd_a.red; assign ka[1] = rd_a.green; assign ka[2] = rd_a.blue;
    assign kb[0] = rd_b.red; assign kb[1] = rd_b.green; assign kb[2] = rd_b.blue;
    assign wa    = WGT_W'(ONE_Q16) - w1_reg;

    // control of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ben)
        begin
            v1_reg <= re;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // multiplies, one product per register, with the weight, status and output registers
    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            w1_reg  <= head.wgt;
            st1_reg <= head.status;
            st2_reg <= st1_reg;
            st3_reg <= st2_reg;
            for (int c = 0; c < 3; c++)
            begin
                pca_reg[c] <= ca[c] * $signed({1'b0, wa});
                pcb_reg[c] <= cb[c] * $signed({1'b0, w1_reg});
                pka_reg[c] <= ka[c] * wa;
                pkb_reg[c] <= kb[c] * w1_reg;
            end
            out_reg <= out_next;
        end
    end

    // sums, floor shift and zeroing of flagged results
    logic signed [50:0] sc [3];
    logic [25:0]        sk [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sc[c] = {pca_reg[c][49], pca_reg[c]} + {pcb_reg[c][49], pcb_reg[c]};
            sk[c] = {1'b0, pka_reg[c]} + {1'b0, pkb_reg[c]};
        end
        out_next       = '0;
        if (st2_reg == ST_OK)
        begin
            out_next.x     = sc[0][47:16];
            out_next.y     = sc[1][47:16];
            out_next.z     = sc[2][47:16];
            out_next.red   = sk[0][23:16];
            out_next.green = sk[1][23:16];
            out_next.blue  = sk[2][23:16];
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = st3_reg;

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("flagged result carries data");
    a_load_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind != KIND_CALC) |=> !v1_reg || !$past(ben))
        else $error("load beat entered the blend pipeline");

endmodule

// ===== hw/rtl/point_cloud_morph_blend_top.sv =====
// ---------------------------------------------------------------------------
// point_cloud_morph_blend_top: linear interpolation morph of two point sets
//
// Input stream (s_*): tuser carries the opcode (load A, load B, compute);
// tdata carries the point index and, for loads, x/y/z (Q16.16) and r/g/b.
// Loads fill the set memories and give no output beat. A compute beat gives
// one output beat (m_*): blended x/y/z and colour in tdata, status in tuser.
// Opcode 3 is accepted and dropped.
// APB port: mode, blend factor and the two set counts; change them only
// while no beat is in flight.
// Throughput: one beat per cycle in both directions while m_tready is high.
// A compute beat passes 17 front stages (classify, then the index fold
// and weight dividers, one quotient bit per stage), one queue slot and
// three back stages (memory read, multiply, sum).
// Reset clears control and configuration; point memories keep whatever they
// hold and must be loaded before use. When m_tready is low the output beat
// holds, the back end stops, the four-entry queue fills and then s_tready
// drops.
// ---------------------------------------------------------------------------
module point_cloud_morph_blend_top import pcmb_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // point_index, in_x, in_y, in_z, in_red, in_green, in_blue
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // out_x, out_y, out_z, out_red, out_green, out_blue
    output logic [1:0]   m_tuser,   // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t cfg_reg;
    logic wr;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t head;

    // configuration registers
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (wr)
        begin
            case (paddr[3:2])
                REG_MODE:    cfg_reg.mode    <= pwdata[0];
                REG_FACTOR:  cfg_reg.factor  <= pwdata[WGT_W-1:0];
                REG_COUNT_A: cfg_reg.count_a <= pwdata[CNT_W-1:0];
                REG_COUNT_B: cfg_reg.count_b <= pwdata[CNT_W-1:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:    prdata = {31'b0, cfg_reg.mode};
            REG_FACTOR:  prdata = {{(32-WGT_W){1'b0}}, cfg_reg.factor};
            REG_COUNT_A: prdata = {{(32-CNT_W){1'b0}}, cfg_reg.count_a};
            REG_COUNT_B: prdata = {{(32-CNT_W){1'b0}}, cfg_reg.count_b};
            default:     prdata = '0;
        endcase
    end

    pcmb_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_idx   (s_tdata[IDX_W-1:0]),
        .in_pt    (s_tdata[IDX_W +: $bits(pt_t)]),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    pcmb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    pcmb_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
